### rtl/rmsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median package
// Widths, the default store size and the control beat handed to each half of
// the sorted cell chain.
// ----------------------------------------------------------------------------
package rmsi_pkg;

   localparam int DATA_W    = 32;
   localparam int MED_W     = 33;
   localparam int CNT_OUT_W = 11;
   localparam int CAPACITY  = 1024;

   // Operation applied to one chain in a cycle.
   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_PUSH,
      OP_POP_INSERT
   } chain_op_type;

   // Control handed to every cell of a chain: the operation and its operand.
   typedef struct packed {
      chain_op_type               op;
      logic signed [DATA_W-1:0]   value;
   } chain_ctl_type;

endpackage

### rtl/rmsi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median channels
// Valid/ready channels for sample beats in and median beats out.
// ----------------------------------------------------------------------------
interface rmsi_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [rmsi_pkg::DATA_W-1:0]     sample;
   logic                                   end_of_set;

   modport source (output valid, output sample, output end_of_set, input ready);
   modport sink   (input valid, input sample, input end_of_set, output ready);
endinterface

interface rmsi_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [rmsi_pkg::MED_W-1:0]      median_halves;
   logic        [rmsi_pkg::CNT_OUT_W-1:0]  held_count;
   logic                                   dropped;
   logic                                   set_done;

   modport source (output valid, output median_halves, output held_count,
                   output dropped, output set_done, input ready);
   modport sink   (input valid, input median_halves, input held_count,
                   input dropped, input set_done, output ready);
endinterface

### rtl/rmsi_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median chain cell
// Holds one stored sample and takes its own, its left or its right
// neighbour's value, or the operand, according to the chain operation.
// ----------------------------------------------------------------------------
module rmsi_cell #(
   parameter int INDEX   = 0,
   parameter int CW      = 11,
   parameter bit DESCEND = 1'b0
) (
   input  logic                                clock,
   input  rmsi_pkg::chain_ctl_type             ctl,
   input  logic [CW-1:0]                       count,
   input  logic signed [rmsi_pkg::DATA_W-1:0]  left_value,
   input  logic                                left_after,
   input  logic signed [rmsi_pkg::DATA_W-1:0]  right_value,
   input  logic                                right_after,
   output logic signed [rmsi_pkg::DATA_W-1:0]  value_ff,
   output logic                                after
);

   localparam bit FIRST = (INDEX == 0);

   logic                               occupied;
   logic                               beyond;
   logic signed [rmsi_pkg::DATA_W-1:0] value_in;

   // A cell lies after the operand when it is empty or its sample belongs
   // further from the chain head than the operand does.
   assign occupied = CW'(INDEX) < count;
   assign beyond   = DESCEND ? (value_ff < ctl.value) : (value_ff > ctl.value);
   assign after    = !occupied || beyond;

   always_comb begin
      value_in = value_ff;
      unique case (ctl.op)
         rmsi_pkg::OP_HOLD: value_in = value_ff;
         rmsi_pkg::OP_INSERT: begin
            if (after) begin
               value_in = left_after ? left_value : ctl.value;
            end
         end
         rmsi_pkg::OP_PUSH: value_in = left_value;
         rmsi_pkg::OP_POP_INSERT: begin
            if (!right_after) begin
               value_in = right_value;
            end else if (FIRST || !after) begin
               value_in = ctl.value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

### rtl/rmsi_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median sorted chain
// A row of cells kept sorted from the head outwards, ascending or
// descending, with the head value available at a fixed place.
// ----------------------------------------------------------------------------
module rmsi_chain #(
   parameter int DEPTH   = 512,
   parameter int CW      = 11,
   parameter bit DESCEND = 1'b0
) (
   input  logic                                clock,
   input  rmsi_pkg::chain_ctl_type             ctl,
   input  logic [CW-1:0]                       count,
   output logic signed [rmsi_pkg::DATA_W-1:0]  head
);

   logic signed [rmsi_pkg::DATA_W-1:0] val_ext   [DEPTH+2];
   logic                               after_ext [DEPTH+2];

   // The operand enters at the head; the far end reads as empty.
   assign val_ext[0]         = ctl.value;
   assign after_ext[0]       = 1'b0;
   assign val_ext[DEPTH+1]   = '0;
   assign after_ext[DEPTH+1] = 1'b1;

   for (genvar i = 0; i < DEPTH; i++) begin : g_stage
      rmsi_cell #(
         .INDEX   (i),
         .CW      (CW),
         .DESCEND (DESCEND)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count),
         .left_value  (val_ext[i]),
         .left_after  (after_ext[i]),
         .right_value (val_ext[i+2]),
         .right_after (after_ext[i+2]),
         .value_ff    (val_ext[i+1]),
         .after       (after_ext[i+1])
      );
   end

   assign head = val_ext[1];

endmodule

### rtl/running_median_sorted_insert.sv
`timescale 1ns / 1ps
// Order: a sample beat accepted by the chains passes through the pending stage
// and then the response register before its median beat is offered.
// Throughput: one sample per cycle while the response channel keeps up, set by
// the shift of the cell chains; the response register lets the next sample in
// while one waits. Reset clears the fill count and all handshake state; the
// stored samples are left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
// Running median by sorted insertion
// Keeps every sample of the current set in two sorted chains of cells, the
// lower half with its largest sample at the head and the upper half with its
// smallest at the head, so the median is always formed from the chain heads.
// ----------------------------------------------------------------------------
module running_median_sorted_insert #(
   parameter int CAPACITY = rmsi_pkg::CAPACITY
) (
   input  logic           clock,
   input  logic           reset,
   rmsi_req_if.sink       req_bus,
   rmsi_rsp_if.source     rsp_bus
);

   // Count width holds the full store; the lower chain takes the extra entry
   // when the capacity is odd.
   localparam int CW      = $clog2(CAPACITY + 1);
   localparam int L_DEPTH = (CAPACITY + 1) / 2;
   localparam int U_DEPTH = CAPACITY / 2;

   logic [CW-1:0]  count_ff, count_in;
   logic [CW:0]    count_plus;
   logic [CW-1:0]  lower_count, upper_count;
   logic           full;
   logic           accept;
   logic           advance;

   logic signed [rmsi_pkg::DATA_W-1:0] lower_head, upper_head;
   rmsi_pkg::chain_ctl_type            lower_ctl, upper_ctl;

   // Pending stage: the chains have been updated and the heads are ready.
   logic           pend_ff, pend_in;
   logic [CW-1:0]  pend_count_ff, pend_count_in;
   logic           pend_drop_ff, pend_drop_in;
   logic           pend_last_ff, pend_last_in;

   // Response register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [rmsi_pkg::MED_W-1:0]    rsp_median_ff, rsp_median_in;
   logic [rmsi_pkg::CNT_OUT_W-1:0]       rsp_count_ff, rsp_count_in;
   logic                                 rsp_drop_ff, rsp_drop_in;
   logic                                 rsp_done_ff, rsp_done_in;

   // The pending beat moves on whenever the response register is free or
   // being emptied; a new sample may enter in the same cycle.
   assign advance        = pend_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !pend_ff || advance;
   assign accept         = req_bus.valid && req_bus.ready;

   assign full        = (count_ff == CW'(CAPACITY));
   assign count_plus  = {1'b0, count_ff} + (CW+1)'(1);
   // The lower half holds the rounded-up half of the samples.
   assign lower_count = count_plus[CW:1];
   assign upper_count = count_ff >> 1;

   // Choose the chain operations. With an even count the new sample belongs
   // to the lower half; if it exceeds the upper head, that head moves down
   // and the sample takes its place in the upper half. With an odd count the
   // mirror image applies. Equal values may go either way, as the median
   // does not depend on their order.
   always_comb begin
      lower_ctl.op    = rmsi_pkg::OP_HOLD;
      lower_ctl.value = req_bus.sample;
      upper_ctl.op    = rmsi_pkg::OP_HOLD;
      upper_ctl.value = req_bus.sample;
      if (accept && !full) begin
         if (!count_ff[0]) begin
            if ((count_ff == '0) || (req_bus.sample <= upper_head)) begin
               lower_ctl.op    = rmsi_pkg::OP_INSERT;
            end else begin
               lower_ctl.op    = rmsi_pkg::OP_PUSH;
               lower_ctl.value = upper_head;
               upper_ctl.op    = rmsi_pkg::OP_POP_INSERT;
            end
         end else begin
            if (req_bus.sample >= lower_head) begin
               upper_ctl.op    = rmsi_pkg::OP_INSERT;
            end else begin
               upper_ctl.op    = rmsi_pkg::OP_PUSH;
               upper_ctl.value = lower_head;
               lower_ctl.op    = rmsi_pkg::OP_POP_INSERT;
            end
         end
      end
   end

   rmsi_chain #(
      .DEPTH   (L_DEPTH),
      .CW      (CW),
      .DESCEND (1'b1)
   ) u_lower (
      .clock (clock),
      .ctl   (lower_ctl),
      .count (lower_count),
      .head  (lower_head)
   );

   rmsi_chain #(
      .DEPTH   (U_DEPTH),
      .CW      (CW),
      .DESCEND (1'b0)
   ) u_upper (
      .clock (clock),
      .ctl   (upper_ctl),
      .count (upper_count),
      .head  (upper_head)
   );

   // Fill count and the pending beat. The count after the insert is kept
   // with the beat, since the end of a set empties the store at once.
   always_comb begin
      count_in      = count_ff;
      pend_in       = pend_ff && !advance;
      pend_count_in = pend_count_ff;
      pend_drop_in  = pend_drop_ff;
      pend_last_in  = pend_last_ff;
      if (accept) begin
         pend_in       = 1'b1;
         pend_count_in = full ? count_ff : count_plus[CW-1:0];
         pend_drop_in  = full;
         pend_last_in  = req_bus.end_of_set;
         if (req_bus.end_of_set) begin
            count_in = '0;
         end else if (!full) begin
            count_in = count_plus[CW-1:0];
         end
      end
   end

   // The median doubled: twice the single middle sample for an odd count,
   // otherwise the sum of the two heads, formed at full width.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_median_in = rsp_median_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_done_in   = rsp_done_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         if (pend_count_ff[0]) begin
            rsp_median_in = {lower_head, 1'b0};
         end else begin
            rsp_median_in = {lower_head[rmsi_pkg::DATA_W-1], lower_head}
                          + {upper_head[rmsi_pkg::DATA_W-1], upper_head};
         end
         rsp_count_in = rmsi_pkg::CNT_OUT_W'(pend_count_ff);
         rsp_drop_in  = pend_drop_ff;
         rsp_done_in  = pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_count_ff <= pend_count_in;
      pend_drop_ff  <= pend_drop_in;
      pend_last_ff  <= pend_last_in;
      rsp_median_ff <= rsp_median_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_done_ff   <= rsp_done_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.median_halves = rsp_median_ff;
   assign rsp_bus.held_count    = rsp_count_ff;
   assign rsp_bus.dropped       = rsp_drop_ff;
   assign rsp_bus.set_done      = rsp_done_ff;

endmodule

### rtl/rmsi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median port checker
// Watches the response channel for handshake rules and for a fill count that
// follows the set boundaries and dropped samples.
// ----------------------------------------------------------------------------
module rmsi_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [rmsi_pkg::MED_W-1:0]   rsp_median_halves,
   input logic [rmsi_pkg::CNT_OUT_W-1:0]      rsp_held_count,
   input logic                                rsp_dropped,
   input logic                                rsp_set_done
);

   logic                             rsp_beat;
   logic                             seen_ff;
   logic                             fresh_ff;
   logic [rmsi_pkg::CNT_OUT_W-1:0]   prev_count_ff;

   assign rsp_beat = rsp_valid && rsp_ready;

   // Remember the last delivered count and whether it closed a set.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         fresh_ff <= 1'b1;
      end else if (rsp_beat) begin
         seen_ff  <= 1'b1;
         fresh_ff <= rsp_set_done;
      end
      if (rsp_beat) begin
         prev_count_ff <= rsp_held_count;
      end
   end

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat withdrawn while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_median_halves)
         && $stable(rsp_held_count) && $stable(rsp_dropped) && $stable(rsp_set_done))
      else $error("response payload changed while stalled");

   a_new_set_starts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && fresh_ff |-> (rsp_held_count == rmsi_pkg::CNT_OUT_W'(1))
         && !rsp_dropped)
      else $error("first beat of a set does not hold exactly one sample");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_ff && !fresh_ff |->
         (rsp_dropped ? (rsp_held_count == prev_count_ff)
                      : (rsp_held_count == prev_count_ff + rmsi_pkg::CNT_OUT_W'(1))))
      else $error("held count did not follow the previous beat");

endmodule

bind running_median_sorted_insert rmsi_checker u_rmsi_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_median_halves (rsp_bus.median_halves),
   .rsp_held_count    (rsp_bus.held_count),
   .rsp_dropped       (rsp_bus.dropped),
   .rsp_set_done      (rsp_bus.set_done)
);

### bench/running_median_sorted_insert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median testbench
// Sends signed sample beats into the sorted-insert median block and checks
// every median beat against a queue-based model of the sorted store. A
// directed table comes first: extremes, equal samples, wide sums and set
// ends. Random sets follow. One set runs past the store's capacity to reach
// the full-store drop. Both channels idle at random, and the response side
// holds off once for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module running_median_sorted_insert_tb;

   localparam int CLOCK_PERIOD     = 20;
   localparam int RESET_CYCLES     = 9;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_SAMPLES   = 160;
   localparam int MAX_REPORTED     = 10;
   localparam int DRAIN_CYCLES     = 8;
   localparam int LONG_HOLD_AFTER  = 200;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DIRECTED_ROWS    = 20;

   localparam logic signed [rmsi_pkg::DATA_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [rmsi_pkg::DATA_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

   // One median beat as it leaves the block, field for field.
   typedef struct packed {
      logic signed [rmsi_pkg::MED_W-1:0]     median_halves;
      logic        [rmsi_pkg::CNT_OUT_W-1:0] held_count;
      logic                                  dropped;
      logic                                  set_done;
   } median_beat_type;

   // One row of the directed table. Where typed is set, the median beat
   // given in the row is what the block must produce; otherwise the sorted
   // store model supplies it.
   typedef struct {
      logic signed [rmsi_pkg::DATA_W-1:0] sample;
      logic                               end_of_set;
      bit                                 typed;
      median_beat_type                    beat;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmsi_req_if req_bus ();
   rmsi_rsp_if rsp_bus ();

   running_median_sorted_insert dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Samples of the current set in ascending order, equal values in arrival
   // order. This is the model's own copy of the block's store.
   logic signed [rmsi_pkg::DATA_W-1:0] held_samples [$];
   // Median beats worked out for accepted sample beats, oldest first.
   median_beat_type                    pending_medians [$];
   // Directed rows in flight, so the acceptance monitor can swap in the
   // typed result where the table gives one.
   directed_row_type                   directed_pending [$];

   int  accepted_samples = 0;
   int  median_beats     = 0;
   int  mismatch_count   = 0;
   int  burst_left       = 0;
   bit  long_hold_done   = 1'b0;

   // The directed table. The first fifteen rows are small enough to work out
   // by hand: single samples at both extremes, pairs of extremes whose sum
   // needs the 33rd bit, a maximum and minimum pair whose sum is minus one,
   // and a set with repeated equal samples. The last rows are left to the
   // model and walk alternating bit patterns through the store.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{SAMPLE_MAX,     1'b1, 1'b1, '{33'sh0_FFFF_FFFE, 11'd1, 1'b0, 1'b1}},
      '{SAMPLE_MIN,     1'b1, 1'b1, '{33'sh1_0000_0000, 11'd1, 1'b0, 1'b1}},
      '{32'sd0,         1'b0, 1'b1, '{33'sh0_0000_0000, 11'd1, 1'b0, 1'b0}},
      '{32'sd0,         1'b1, 1'b1, '{33'sh0_0000_0000, 11'd2, 1'b0, 1'b1}},
      '{SAMPLE_MAX,     1'b0, 1'b1, '{33'sh0_FFFF_FFFE, 11'd1, 1'b0, 1'b0}},
      '{SAMPLE_MAX,     1'b1, 1'b1, '{33'sh0_FFFF_FFFE, 11'd2, 1'b0, 1'b1}},
      '{SAMPLE_MIN,     1'b0, 1'b1, '{33'sh1_0000_0000, 11'd1, 1'b0, 1'b0}},
      '{SAMPLE_MIN,     1'b1, 1'b1, '{33'sh1_0000_0000, 11'd2, 1'b0, 1'b1}},
      '{SAMPLE_MAX,     1'b0, 1'b1, '{33'sh0_FFFF_FFFE, 11'd1, 1'b0, 1'b0}},
      '{SAMPLE_MIN,     1'b1, 1'b1, '{33'sh1_FFFF_FFFF, 11'd2, 1'b0, 1'b1}},
      '{-32'sd1,        1'b0, 1'b1, '{33'sh1_FFFF_FFFE, 11'd1, 1'b0, 1'b0}},
      '{32'sd5,         1'b0, 1'b1, '{33'sh0_0000_0004, 11'd2, 1'b0, 1'b0}},
      '{32'sd3,         1'b0, 1'b1, '{33'sh0_0000_0006, 11'd3, 1'b0, 1'b0}},
      '{32'sd3,         1'b0, 1'b1, '{33'sh0_0000_0006, 11'd4, 1'b0, 1'b0}},
      '{32'sd3,         1'b1, 1'b1, '{33'sh0_0000_0006, 11'd5, 1'b0, 1'b1}},
      '{32'sh5555_5555, 1'b0, 1'b0, '{33'sh0, 11'd0, 1'b0, 1'b0}},
      '{32'shAAAA_AAAA, 1'b0, 1'b0, '{33'sh0, 11'd0, 1'b0, 1'b0}},
      '{SAMPLE_MIN,     1'b0, 1'b0, '{33'sh0, 11'd0, 1'b0, 1'b0}},
      '{32'sd7,         1'b0, 1'b0, '{33'sh0, 11'd0, 1'b0, 1'b0}},
      '{-32'sd7,        1'b1, 1'b0, '{33'sh0, 11'd0, 1'b0, 1'b0}}
   };

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Inserts one sample into the model store after any equal entries, forms
   // the doubled median at full width and empties the store at a set end.
   // A sample that meets a full store is dropped and leaves the store alone.
   function automatic median_beat_type insert_and_median(
      input logic signed [rmsi_pkg::DATA_W-1:0] sample,
      input logic                               last
   );
      median_beat_type beat;
      int              pos;
      int              count;
      longint          doubled;
      beat.dropped = 1'b0;
      if (held_samples.size() < rmsi_pkg::CAPACITY) begin
         pos = 0;
         while (pos < held_samples.size() && held_samples[pos] <= sample) pos++;
         held_samples.insert(pos, sample);
      end else begin
         beat.dropped = 1'b1;
      end
      count = held_samples.size();
      if (count % 2 == 1) begin
         doubled = 2 * longint'(held_samples[count / 2]);
      end else begin
         doubled = longint'(held_samples[count / 2 - 1]) + longint'(held_samples[count / 2]);
      end
      beat.median_halves = doubled[rmsi_pkg::MED_W-1:0];
      beat.held_count    = count[rmsi_pkg::CNT_OUT_W-1:0];
      beat.set_done      = last;
      if (last) held_samples.delete();
      return beat;
   endfunction

   // Sample values are drawn to stress the store: full-range values for bit
   // coverage, a narrow band for plenty of equal samples, and values at or
   // near the extremes so that pairs of middles need the wide sum.
   function automatic logic signed [rmsi_pkg::DATA_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return SAMPLE_MAX;
               1:       return SAMPLE_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
         1:       return SAMPLE_MAX - rmsi_pkg::DATA_W'($urandom_range(0, 3));
         2:       return SAMPLE_MIN + rmsi_pkg::DATA_W'($urandom_range(0, 3));
         3, 4, 5: return rmsi_pkg::DATA_W'($urandom_range(0, 20)) - 32'sd10;
         default: return $urandom;
      endcase
   endfunction

   // Offers one sample beat and returns at the edge where it is taken. The
   // sender works in bursts; a gap of random length may open before a new
   // burst, and sometimes there is none, so long unbroken streams occur too.
   task automatic send_beat(
      input logic signed [rmsi_pkg::DATA_W-1:0] sample,
      input logic                               last
   );
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.sample     <= sample;
      req_bus.end_of_set <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // Random sets of mostly modest length. Now and then a set is cut short by
   // an early end flag, which leaves odd and even counts in every mix.
   task automatic send_random_sets(input int sample_total);
      int sent;
      int set_len;
      sent = 0;
      while (sent < sample_total) begin
         set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(31, 120)
                                               : $urandom_range(1, 30);
         for (int i = 0; i < set_len; i++) begin
            send_beat(pick_sample(), (i == set_len - 1) || ($urandom_range(0, 19) == 0));
         end
         sent += set_len;
      end
   endtask

   // Acceptance monitor: each sample beat taken by the block is run through
   // the model at the same edge, and its median beat joins the queue.
   always @(posedge clock) begin
      median_beat_type  beat;
      directed_row_type row;
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
         beat = insert_and_median(req_bus.sample, req_bus.end_of_set);
         if (directed_pending.size() > 0) begin
            row = directed_pending.pop_front();
            if (row.typed) beat = row.beat;
         end
         pending_medians.push_back(beat);
         accepted_samples++;
      end
   end

   // Result monitor: every median beat taken from the block is compared with
   // the oldest outstanding one. A beat with nothing outstanding is an error.
   always @(posedge clock) begin
      median_beat_type want;
      median_beat_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = '{rsp_bus.median_halves, rsp_bus.held_count, rsp_bus.dropped,
                 rsp_bus.set_done};
         if (pending_medians.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
               $display("median beat %0d arrived with none outstanding: median_halves %0d",
                        median_beats, got.median_halves);
         end else begin
            want = pending_medians.pop_front();
            if (got.median_halves !== want.median_halves ||
                got.held_count    !== want.held_count    ||
                got.dropped       !== want.dropped       ||
                got.set_done      !== want.set_done) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED) begin
                  $write("median beat %0d mismatch (expected/actual): median_halves %0d/%0d",
                         median_beats, want.median_halves, got.median_halves);
                  $display(" held_count %0d/%0d dropped %0b/%0b set_done %0b/%0b",
                           want.held_count, got.held_count, want.dropped, got.dropped,
                           want.set_done, got.set_done);
               end
            end
         end
         median_beats++;
      end
   end

   // Receiver. Runs of ready alternate with short stalls, with the odd long
   // run without any stall. Once enough samples have gone in, ready is held
   // low for a long stretch so that the block fills and stalls its input.
   initial begin
      int run_len;
      int stall_len;
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!long_hold_done && accepted_samples >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
         run_len   = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(1, 6);
         stall_len = $urandom_range(0, 5);
         rsp_bus.ready <= 1'b1;
         repeat (run_len) @(posedge clock);
         if (stall_len > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   // Watchdog. The limit is several times the slowest correct run: some
   // twelve hundred and fifty samples, each meeting the sender's longest gap
   // and the receiver's longest stall, plus the long hold-off.
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d median beats outstanding",
               cycles, pending_medians.size());
      $display("== FAIL ==");
      $finish;
   end

   // Stimulus: reset, the directed table, random sets, one set that overruns
   // the store so that the full-store drop is seen, then more random sets.
   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.sample     <= '0;
      req_bus.end_of_set <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         directed_pending.push_back(directed_rows[i]);
         send_beat(directed_rows[i].sample, directed_rows[i].end_of_set);
      end

      send_random_sets(RANDOM_SAMPLES / 2);

      // The store reaches its capacity here; the last few samples of this
      // set are dropped and report a full count.
      for (int i = 0; i < rmsi_pkg::CAPACITY + 8; i++) begin
         send_beat(pick_sample(), i == rmsi_pkg::CAPACITY + 7);
      end

      send_random_sets(RANDOM_SAMPLES - RANDOM_SAMPLES / 2);
      req_bus.valid <= 1'b0;

      // Wait for the last median beats, then DRAIN_CYCLES more to catch any
      // stray beat the block might still produce.
      while (pending_medians.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
